>>> sv/bbs_pkg.sv
// Shared types and constants for the beep burst sequencer.
`timescale 1ns / 1ps
package bbs_pkg;

  localparam int TIME_W     = 32;
  localparam int CNT_W      = 8;
  localparam int LEN_W      = 16;
  localparam int CFG_DATA_W = 16;

  // serial units walk one bit of the time word per cycle
  localparam int SER_STEPS = TIME_W;
  localparam int SER_CNT_W = $clog2(SER_STEPS);

  localparam logic [TIME_W-1:0] START_DELAY_MS = 32'd30;

  localparam logic [LEN_W-1:0] NORMAL_ON_RST = 16'd100;
  localparam logic [LEN_W-1:0] GAP_MIN_RST   = 16'd200;
  localparam logic [LEN_W-1:0] GAP_MAX_RST   = 16'd1000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_NORMAL = 2'd1,
    OP_RAPID  = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_NORMAL_ON = 2'd1,
    REG_GAP_MIN   = 2'd2,
    REG_GAP_MAX   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic carry;
  } alu_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/bbs_in_if.sv
// Command input channel.
`timescale 1ns / 1ps
interface bbs_in_if;
  import bbs_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [TIME_W-1:0]   now_ms;
  logic [CNT_W-1:0]    beep_count;
  logic [LEN_W-1:0]    pulse_ms;
  logic [LEN_W-1:0]    pause_ms;
  logic [TIME_W-1:0]   random_word;

  modport source (output valid, operation, now_ms, beep_count, pulse_ms, pause_ms,
                  random_word, input ready);
  modport sink   (input valid, operation, now_ms, beep_count, pulse_ms, pause_ms,
                  random_word, output ready);
endinterface

>>> sv/bbs_out_if.sv
// Result output channel.
`timescale 1ns / 1ps
interface bbs_out_if;
  import bbs_pkg::*;

  logic             valid;
  logic             ready;
  logic             buzzer_level;
  logic [CNT_W-1:0] beeps_left;

  modport source (output valid, buzzer_level, beeps_left, input ready);
  modport sink   (input valid, buzzer_level, beeps_left, output ready);
endinterface

>>> sv/bbs_cfg_if.sv
// Register write channel.
`timescale 1ns / 1ps
interface bbs_cfg_if;
  import bbs_pkg::*;

  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/beep_burst_sequencer_top.sv
// Beep burst sequencer top level: command sequencing, schedule state and registers.
`timescale 1ns / 1ps
// Usage:
//   in_ch   commands (tick / normal beep / rapid beep / stop) with the current ms time.
//           One transfer is taken at a time; ready is high only when the sequencer is idle.
//   out_ch  one result per command: buzzer level and pulses still to start, held in an
//           output register, so the next command is taken while a result waits.
//   cfg_ch  register writes (enable, normal on time, gap min, gap max); always ready.
//           Write only while no command is in flight.
// Command paths, accept to the result in the output register:
//   stop, rapid beep, disabled tick: straight to the last step
//   tick with nothing due: serial compare
//   normal beep: serial add of the 30 ms start delay
//   tick that starts or ends a pulse: serial compare, then serial add
//   Compare and add run in the bit-serial 32-bit adder, one bit per cycle; the random gap
//   remainder runs in a serial divider alongside the compare and adds no step.
//   A new command is taken only once the last one has handed over its result.
// Reset (synchronous, rst_n low): idle, nothing sounding, count and schedule cleared,
//   registers back to enable 1, 100 ms on, gap min 200 ms, gap max 1000 ms.
// Receiver stall: the result sits in the output register; a finished command waits
//   in its last step until the register frees, and in_ch stays not ready meanwhile.
module beep_burst_sequencer_top (
  input  logic          clk,
  input  logic          rst_n,
  bbs_in_if.sink        in_ch,
  bbs_out_if.source     out_ch,
  bbs_cfg_if.sink       cfg_ch
);
  import bbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a command
    S_CMP  = 4'b0010,  // tick: time compare and gap remainder running
    S_ADD  = 4'b0100,  // serial add into stop or next time
    S_DONE = 4'b1000   // hand result to the output register
  } state_t;

  state_t state_r;

  // registers
  logic             enable_r;
  logic [LEN_W-1:0] normal_on_r, gap_min_r, gap_max_r;

  // schedule state
  logic [CNT_W-1:0]  remaining_r;
  logic              sounding_r;
  logic [TIME_W-1:0] stop_time_r, next_time_r;
  logic [LEN_W-1:0]  on_len_r, gap_len_r;
  logic              fixed_r;

  // per-command scratch
  op_t               op_r;
  logic [TIME_W-1:0] now_r;
  logic              dest_stop_r;  // add result goes to stop time, else next time

  // output register
  logic             out_valid_r;
  logic             out_level_r;
  logic [CNT_W-1:0] out_left_r;

  // serial units
  logic              alu_start, alu_sub;
  logic [TIME_W-1:0] alu_a, alu_b, alu_sum;
  alu_stat_t         alu_stat;
  logic              div_start;
  logic [LEN_W-1:0]  div_rem, div_divisor;
  div_stat_t         div_stat;

  logic             in_xfer, cfg_xfer, out_free;
  logic             tick_ge, start_c, stop_c;
  logic [LEN_W-1:0] rand_gap, gap_val;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.buzzer_level = out_level_r;
  assign out_ch.beeps_left   = out_left_r;

  // tick decision after the compare (carry = now >= selected time)
  assign tick_ge = alu_stat.carry;
  assign start_c = !sounding_r && (remaining_r != '0) && tick_ge;
  assign stop_c  = sounding_r && tick_ge;

  // random gap: min + rnd % (max - min), plain min when the range is empty
  assign div_divisor = gap_max_r - gap_min_r;
  assign rand_gap    = (gap_max_r > gap_min_r) ? (gap_min_r + div_rem) : gap_min_r;
  assign gap_val     = fixed_r ? gap_len_r : rand_gap;

  always_comb begin
    alu_start = 1'b0;
    alu_sub   = 1'b0;
    alu_a     = now_r;
    alu_b     = {{(TIME_W-LEN_W){1'b0}}, on_len_r};
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        alu_a = in_ch.now_ms;
        if (in_xfer) begin
          case (in_ch.operation)
            OP_TICK: begin
              if (enable_r) begin
                alu_start = 1'b1;
                alu_sub   = 1'b1;
                alu_b     = sounding_r ? stop_time_r : next_time_r;
                div_start = 1'b1;
              end
            end
            OP_NORMAL: begin
              alu_start = 1'b1;
              alu_b     = START_DELAY_MS;
            end
            default: ;
          endcase
        end
      end
      S_CMP: begin
        if (alu_stat.done && (start_c || stop_c)) begin
          alu_start = 1'b1;
          alu_b     = start_c ? {{(TIME_W-LEN_W){1'b0}}, on_len_r}
                              : {{(TIME_W-LEN_W){1'b0}}, gap_val};
        end
      end
      default: ;
    endcase
  end

  bbs_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .sub   (alu_sub),
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .stat  (alu_stat)
  );

  bbs_serial_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_ch.random_word),
    .divisor   (div_divisor),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // control and schedule state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      normal_on_r <= NORMAL_ON_RST;
      gap_min_r   <= GAP_MIN_RST;
      gap_max_r   <= GAP_MAX_RST;
      remaining_r <= '0;
      sounding_r  <= 1'b0;
      stop_time_r <= '0;
      next_time_r <= '0;
      fixed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        unique case (cfg_ch.index)
          REG_ENABLE: begin
            enable_r <= cfg_ch.data[0];
            if (!cfg_ch.data[0]) sounding_r <= 1'b0;
          end
          REG_NORMAL_ON: normal_on_r <= cfg_ch.data;
          REG_GAP_MIN:   gap_min_r   <= cfg_ch.data;
          REG_GAP_MAX:   gap_max_r   <= cfg_ch.data;
        endcase
      end

      // loaded from the last step, held until the receiver takes it
      out_valid_r <= ((state_r == S_DONE) && out_free) || (out_valid_r && !out_ch.ready);

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_ch.operation)
              OP_TICK: begin
                if (enable_r) begin
                  state_r <= S_CMP;
                end else begin
                  sounding_r <= 1'b0;  // disabled: silence, keep count
                  state_r    <= S_DONE;
                end
              end
              OP_NORMAL: begin
                sounding_r  <= 1'b0;
                remaining_r <= in_ch.beep_count;
                fixed_r     <= 1'b0;
                state_r     <= S_ADD;
              end
              OP_RAPID: begin
                sounding_r <= 1'b0;
                if ((in_ch.beep_count == '0) || (in_ch.pulse_ms == '0)) begin
                  remaining_r <= '0;
                end else begin
                  remaining_r <= in_ch.beep_count;
                  fixed_r     <= 1'b1;
                  next_time_r <= in_ch.now_ms;
                end
                state_r <= S_DONE;
              end
              default: begin  // stop
                sounding_r  <= 1'b0;
                remaining_r <= '0;
                state_r     <= S_DONE;
              end
            endcase
          end
        end
        S_CMP: begin
          if (alu_stat.done) begin
            if (start_c) begin
              sounding_r  <= 1'b1;
              remaining_r <= remaining_r - CNT_W'(1);
              state_r     <= S_ADD;
            end else if (stop_c) begin
              sounding_r <= 1'b0;
              state_r    <= S_ADD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_ADD: begin
          if (alu_stat.done) begin
            if (dest_stop_r) stop_time_r <= alu_sum;
            else             next_time_r <= alu_sum;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_r  <= in_ch.operation;
          now_r <= in_ch.now_ms;
          case (in_ch.operation)
            OP_NORMAL: begin
              on_len_r    <= normal_on_r;
              dest_stop_r <= 1'b0;
            end
            OP_RAPID: begin
              if ((in_ch.beep_count != '0) && (in_ch.pulse_ms != '0)) begin
                on_len_r  <= in_ch.pulse_ms;
                gap_len_r <= in_ch.pause_ms;
              end
            end
            default: ;
          endcase
        end
      end
      S_CMP: begin
        if (alu_stat.done) dest_stop_r <= start_c;
      end
      S_DONE: begin
        if (out_free) begin
          out_level_r <= sounding_r;
          out_left_r  <= remaining_r;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // divider and adder start together on a tick and must finish together
  a_div_with_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && alu_stat.done) |-> div_stat.done)
    else $error("remainder not ready at end of tick compare");

  // a pulse only starts when a count was left
  a_start_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sounding_r) |-> ($past(remaining_r) != '0))
    else $error("pulse started with zero count");

  // a disabled tick always reports the buzzer off
  a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == OP_TICK && !enable_r) |-> !sounding_r)
    else $error("buzzer on after disabled tick");

  // no serial unit left running while a new command can be taken
  a_idle_units_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!alu_stat.busy && !div_stat.busy))
    else $error("serial unit busy in idle");
`endif

endmodule

>>> sv/bbs_serial_alu.sv
// Bit-serial 32-bit adder/subtractor, LSB first, one bit per cycle.
`timescale 1ns / 1ps
module bbs_serial_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      sub,
  input  logic [bbs_pkg::TIME_W-1:0] a,
  input  logic [bbs_pkg::TIME_W-1:0] b,
  output logic [bbs_pkg::TIME_W-1:0] sum,
  output bbs_pkg::alu_stat_t         stat
);
  import bbs_pkg::*;

  logic [TIME_W-1:0]    a_r, b_r, sum_r;
  logic                 carry_r, sub_r;
  logic [SER_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;

  logic b_bit, s_bit, c_nxt;

  always_comb begin
    b_bit = b_r[0] ^ sub_r;
    s_bit = a_r[0] ^ b_bit ^ carry_r;
    c_nxt = (a_r[0] & b_bit) | (a_r[0] & carry_r) | (b_bit & carry_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SER_CNT_W'(1);
        if (cnt_r == SER_CNT_W'(SER_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= a;
      b_r     <= b;
      carry_r <= sub;  // two's complement: +1 on subtract
      sub_r   <= sub;
    end else if (busy_r) begin
      a_r     <= a_r >> 1;
      b_r     <= b_r >> 1;
      sum_r   <= {s_bit, sum_r[TIME_W-1:1]};
      carry_r <= c_nxt;
    end
  end

  assign sum        = sum_r;
  assign stat.busy  = busy_r;
  assign stat.done  = done_r;
  assign stat.carry = carry_r;  // on subtract: 1 means a >= b
endmodule

>>> sv/bbs_serial_mod.sv
// Restoring serial remainder: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module bbs_serial_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bbs_pkg::TIME_W-1:0] dividend,
  input  logic [bbs_pkg::LEN_W-1:0]  divisor,
  output logic [bbs_pkg::LEN_W-1:0]  remainder,
  output bbs_pkg::div_stat_t         stat
);
  import bbs_pkg::*;

  logic [TIME_W-1:0]    q_r;
  logic [LEN_W-1:0]     rem_r, d_r;
  logic [SER_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;

  logic [LEN_W:0]   trial;
  logic [LEN_W+1:0] diff;
  logic [LEN_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, q_r[TIME_W-1]};
    diff  = {1'b0, trial} - {2'b00, d_r};
    if (!diff[LEN_W+1]) begin
      rem_nxt = diff[LEN_W-1:0];
    end else begin
      rem_nxt = trial[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SER_CNT_W'(1);
        if (cnt_r == SER_CNT_W'(SER_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

>>> tb/bbs_burst_check.sv
// Predicts the sequencer's result for every accepted command and compares it.
`timescale 1ns / 1ps
module bbs_burst_check (
  input  logic clk,
  input  logic rst_n,
  bbs_in_if    cmd,
  bbs_out_if   res,
  bbs_cfg_if   cfg,
  output int   pending,
  output int   errors
);
  import bbs_pkg::*;

  typedef struct packed {
    logic             level;
    logic [CNT_W-1:0] left;
  } beep_result_t;

  // register copy
  logic              reg_enable;
  logic [LEN_W-1:0]  reg_normal_on;
  logic [LEN_W-1:0]  reg_gap_min;
  logic [LEN_W-1:0]  reg_gap_max;

  // burst schedule
  logic [CNT_W-1:0]  left_cnt;
  logic              buzzing;
  logic [TIME_W-1:0] off_at;
  logic [TIME_W-1:0] start_at;
  logic [LEN_W-1:0]  burst_on;
  logic [LEN_W-1:0]  burst_gap;
  logic              fixed_gap;

  beep_result_t due_results[$];
  int           n_taken;
  int           n_seen;
  int           mismatches;

  assign pending = n_taken - n_seen;
  assign errors  = mismatches;

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("[%0t] MISMATCH result %0d: %s", $realtime, n_seen, msg);
    mismatches++;
  endtask

  function automatic beep_result_t advance_schedule(
    op_t op, logic [TIME_W-1:0] now, logic [CNT_W-1:0] count,
    logic [LEN_W-1:0] pulse, logic [LEN_W-1:0] pause, logic [TIME_W-1:0] rnd);
    logic [TIME_W-1:0] on_ext;
    logic [TIME_W-1:0] fixed_ext;
    logic [TIME_W-1:0] min_ext;
    logic [TIME_W-1:0] max_ext;
    logic [TIME_W-1:0] offset;
    beep_result_t      r;
    on_ext    = TIME_W'(burst_on);
    fixed_ext = TIME_W'(burst_gap);
    min_ext   = TIME_W'(reg_gap_min);
    max_ext   = TIME_W'(reg_gap_max);
    offset    = '0;
    if (max_ext > min_ext) offset = rnd % (max_ext - min_ext);
    case (op)
      OP_TICK: begin
        if (!reg_enable) begin
          buzzing = 1'b0;
        end else if (!buzzing && left_cnt != '0 && now >= start_at) begin
          buzzing  = 1'b1;
          off_at   = now + on_ext;
          left_cnt = left_cnt - 1'b1;
        end else if (buzzing && now >= off_at) begin
          buzzing  = 1'b0;
          start_at = fixed_gap ? now + fixed_ext : now + min_ext + offset;
        end
      end
      OP_NORMAL: begin
        buzzing   = 1'b0;
        left_cnt  = count;
        burst_on  = reg_normal_on;
        fixed_gap = 1'b0;
        start_at  = now + START_DELAY_MS;
      end
      OP_RAPID: begin
        buzzing = 1'b0;
        if (count == '0 || pulse == '0) begin
          left_cnt = '0;
        end else begin
          left_cnt  = count;
          burst_on  = pulse;
          burst_gap = pause;
          fixed_gap = 1'b1;
          start_at  = now;
        end
      end
      default: begin
        buzzing  = 1'b0;
        left_cnt = '0;
      end
    endcase
    r.level = buzzing;
    r.left  = left_cnt;
    return r;
  endfunction

  always @(posedge clk) begin : track
    beep_result_t want;
    if (!rst_n) begin
      reg_enable    = 1'b1;
      reg_normal_on = NORMAL_ON_RST;
      reg_gap_min   = GAP_MIN_RST;
      reg_gap_max   = GAP_MAX_RST;
      left_cnt      = '0;
      buzzing       = 1'b0;
      off_at        = '0;
      start_at      = '0;
      burst_on      = '0;
      burst_gap     = '0;
      fixed_gap     = 1'b0;
      due_results.delete();
      n_taken <= 0;
      n_seen  <= 0;
    end else begin
      // results first, so a result is never matched against a command of this edge
      if (res.valid && res.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result level %0b left %0d",
                                    res.buzzer_level, res.beeps_left));
        end else begin
          want = due_results.pop_front();
          if (res.buzzer_level !== want.level)
            report_mismatch($sformatf("buzzer_level %0b, want %0b",
                                      res.buzzer_level, want.level));
          if (res.beeps_left !== want.left)
            report_mismatch($sformatf("beeps_left %0d, want %0d",
                                      res.beeps_left, want.left));
          n_seen <= n_seen + 1;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ENABLE: begin
            reg_enable = cfg.data[0];
            if (!cfg.data[0]) buzzing = 1'b0;
          end
          REG_NORMAL_ON: reg_normal_on = cfg.data[LEN_W-1:0];
          REG_GAP_MIN:   reg_gap_min   = cfg.data[LEN_W-1:0];
          REG_GAP_MAX:   reg_gap_max   = cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        due_results.push_back(advance_schedule(cmd.operation, cmd.now_ms, cmd.beep_count,
                                               cmd.pulse_ms, cmd.pause_ms,
                                               cmd.random_word));
        n_taken <= n_taken + 1;
      end
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, command and register stimulus, result stalls, verdict.
`timescale 1ns / 1ps
module tb;
  import bbs_pkg::*;

  // Worst case accept-to-result is a tick that starts or ends a pulse.
  localparam int LATENCY        = 70;
  // Long receiver hold: the output register fills and in_ch stalls behind it.
  localparam int HOLD_CYCLES    = 400;
  // Longest quiet stretch of a correct run is a hold plus latency plus both gaps;
  // the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 10;
  localparam int PHASE_CMDS     = 95;

  logic clk = 1'b0;
  logic rst_n;

  bbs_in_if  in_ch ();
  bbs_out_if out_ch ();
  bbs_cfg_if cfg_ch ();

  int pending;
  int errors;

  beep_burst_sequencer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bbs_burst_check burst_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (in_ch),
    .res     (out_ch),
    .cfg     (cfg_ch),
    .pending (pending),
    .errors  (errors)
  );

  always #5 clk = ~clk;

  // Process state; hold_asks is shared between sender and receiver processes.
  int                hold_asks   = 0;
  int                holds_done  = 0;
  int                cmds_sent   = 0;
  logic              sender_calm = 1'b0;
  logic [TIME_W-1:0] clock_ms    = '0;  // the sender's notion of the ms clock

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One command transfer. Valid stays up into the next call unless a gap is drawn,
  // so back-to-back commands never see valid dropped and raised in one step.
  task automatic send_cmd(op_t op, logic [TIME_W-1:0] now, logic [CNT_W-1:0] count,
                          logic [LEN_W-1:0] pulse, logic [LEN_W-1:0] pause,
                          logic [TIME_W-1:0] rnd);
    int gap;
    gap = sender_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.now_ms      <= now;
    in_ch.beep_count  <= count;
    in_ch.pulse_ms    <= pulse;
    in_ch.pause_ms    <= pause;
    in_ch.random_word <= rnd;
    do @(posedge clk); while (!in_ch.ready);
    cmds_sent++;
  endtask

  // Tick at a given time; the operand fields are ignored by the block but still toggle.
  task automatic tick_at(logic [TIME_W-1:0] now, logic [TIME_W-1:0] rnd);
    send_cmd(OP_TICK, now, 8'($urandom), 16'($urandom), 16'($urandom), rnd);
  endtask

  // Stop offering and wait until every expected result has been transferred.
  // The first edge is always waited so a transfer at the current edge is counted.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Leaves cfg valid high; the caller drops it after the last write.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Only called with nothing in flight. Upper enable bits are random: only bit 0 counts.
  task automatic set_regs(logic en, logic [LEN_W-1:0] on_ms, logic [LEN_W-1:0] gmin,
                          logic [LEN_W-1:0] gmax);
    write_reg(REG_ENABLE, {15'($urandom), en});
    write_reg(REG_NORMAL_ON, on_ms);
    write_reg(REG_GAP_MIN, gmin);
    write_reg(REG_GAP_MAX, gmax);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed bursts: a beep command followed by a run of ticks with the
  // ms clock moving forward, sprinkled with stops, time jumps and raw noise commands.
  task automatic random_traffic(int n);
    int               sent;
    int               ticks;
    int               k;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] pulse;
    logic [LEN_W-1:0] pause;
    sent = 0;
    while (sent < n) begin
      sender_calm = ($urandom_range(0, 5) == 0);
      k = $urandom_range(0, 19);
      if (k == 0) begin
        // noise: every field fully random
        send_cmd(op_t'($urandom_range(0, 3)), $urandom, 8'($urandom), 16'($urandom),
                 16'($urandom), $urandom);
        sent++;
        continue;
      end
      // sender pause until all results are back
      if (k == 1) drain();
      // jump the clock anywhere, or close to the wrap point
      if (k == 2) clock_ms = $urandom;
      if (k == 3) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);

      k = $urandom_range(0, 19);
      count = (k == 0) ? '0 : (k == 1) ? 8'hFF : (k == 2) ? 8'($urandom) :
              8'($urandom_range(1, 5));
      if ($urandom_range(0, 1) == 0) begin
        send_cmd(OP_NORMAL, clock_ms, count, 16'($urandom), 16'($urandom), $urandom);
      end else begin
        k = $urandom_range(0, 19);
        pulse = (k == 0) ? '0 : (k == 1) ? 16'hFFFF : (k == 2) ? 16'($urandom) :
                16'($urandom_range(1, 8));
        k = $urandom_range(0, 19);
        pause = (k == 0) ? 16'hFFFF : (k == 1) ? 16'($urandom) :
                16'($urandom_range(0, 8));
        send_cmd(OP_RAPID, clock_ms, count, pulse, pause, $urandom);
      end
      sent++;

      ticks = $urandom_range(4, 30);
      while (ticks > 0 && sent < n) begin
        if ($urandom_range(0, 29) == 0) clock_ms += $urandom_range(100, 70000);
        else clock_ms += $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0)
          send_cmd(OP_STOP, clock_ms, 8'($urandom), 16'($urandom), 16'($urandom),
                   $urandom);
        else
          tick_at(clock_ms, $urandom);
        sent++;
        ticks--;
      end
    end
  endtask

  // Receiver: random ready gaps, calm stretches with ready held high, and on request
  // one long hold counted here so the sender keeps pushing against a full block.
  initial begin : receiver
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_done != hold_asks) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int               p;
    logic             en;
    logic [LEN_W-1:0] on_ms;
    logic [LEN_W-1:0] gmin;
    logic [LEN_W-1:0] gmax;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_TICK;
    in_ch.now_ms      <= '0;
    in_ch.beep_count  <= '0;
    in_ch.pulse_ms    <= '0;
    in_ch.pause_ms    <= '0;
    in_ch.random_word <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_ENABLE;
    cfg_ch.data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset register values: 100 ms on, gap 200..1000 ms ----
    tick_at(32'd0, 32'd0);                                   // idle tick
    send_cmd(OP_STOP, 32'd0, 8'd0, 16'd0, 16'd0, 32'd0);
    send_cmd(OP_RAPID, 32'd10, 8'd0, 16'd5, 16'd5, 32'd0);   // zero count only clears
    send_cmd(OP_RAPID, 32'd20, 8'd3, 16'd0, 16'd5, 32'd0);   // zero pulse only clears
    send_cmd(OP_NORMAL, 32'd0, 8'd0, 16'd0, 16'd0, 32'd0);   // zero normal beep
    tick_at(32'd100, 32'd0);                                 // nothing to sound
    send_cmd(OP_NORMAL, 32'd1000, 8'd2, 16'd0, 16'd0, 32'd0); // first pulse due at 1030
    tick_at(32'd1029, 32'd0);                                // one ms early
    tick_at(32'd1030, 32'd0);                                // pulse starts
    tick_at(32'd1130, 32'hFFFF_FFFF);                        // pulse ends, random gap
    tick_at(32'd1425, 32'd0);                                // second pulse
    send_cmd(OP_NORMAL, 32'd1450, 8'hFF, 16'd0, 16'd0, 32'd0); // beep cuts running pulse
    send_cmd(OP_RAPID, 32'hFFFF_FFF0, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd0);
    tick_at(32'hFFFF_FFFF, 32'd0);                           // stop time wraps past zero
    tick_at(32'hFFFF_FFFF, 32'd0);                           // wrapped stop already passed
    tick_at(32'd0, 32'd0);                                   // wrapped start not yet due
    tick_at(32'd65534, 32'd0);
    send_cmd(OP_STOP, 32'd65534, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

    // Enable dropped while a pulse runs, then a disabled tick keeps the count.
    drain();
    set_regs(1'b1, 16'd7, 16'd2, 16'd9);
    send_cmd(OP_RAPID, 32'd5000, 8'd3, 16'd50, 16'd4, 32'd0);
    tick_at(32'd5000, 32'd0);
    drain();
    set_regs(1'b0, 16'd7, 16'd2, 16'd9);
    tick_at(32'd5001, 32'd0);
    drain();
    set_regs(1'b1, 16'd7, 16'd2, 16'd9);
    tick_at(32'd5002, 32'd0);
    clock_ms = 32'd10000;

    // ---- random phases, each under its own register setting ----
    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin en = 1'b1; on_ms = 16'd4;     gmin = 16'd2;     gmax = 16'd10;    end
        1: begin en = 1'b1; on_ms = 16'd1;     gmin = 16'd0;     gmax = 16'hFFFF;  end
        2: begin en = 1'b1; on_ms = 16'd3;     gmin = 16'd6;     gmax = 16'd2;     end
        3: begin en = 1'b1; on_ms = 16'hFFFF;  gmin = 16'hFFFF;  gmax = 16'hFFFF;  end
        4: begin en = 1'b0; on_ms = 16'd5;     gmin = 16'd1;     gmax = 16'd8;     end
        5: begin en = 1'b1; on_ms = 16'd2;     gmin = 16'd0;     gmax = 16'd0;     end
        default: begin
          en    = ($urandom_range(0, 5) != 0);
          on_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) :
                                                16'($urandom_range(1, 10));
          gmin  = 16'($urandom_range(0, 6));
          gmax  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        end
      endcase
      set_regs(en, on_ms, gmin, gmax);
      // one long receiver hold while commands keep coming
      if (p == 2) hold_asks++;
      random_traffic(PHASE_CMDS);
    end

    // ---- wind down: all results back, then a quiet tail for stray results ----
    drain();
    repeat (2 * LATENCY) @(posedge clk);

    $display("Run covered %0d commands under %0d register settings plus reset values,",
             cmds_sent, PHASES + 3);
    $display("with wrapped time, disabled ticks, long output holds and drained pauses.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bbs_pkg.sv
sv/bbs_in_if.sv
sv/bbs_out_if.sv
sv/bbs_cfg_if.sv
sv/bbs_serial_alu.sv
sv/bbs_serial_mod.sv
sv/beep_burst_sequencer_top.sv
tb/bbs_burst_check.sv
tb/tb.sv
